[hw/rtl/cre_pkg.sv]
// Shared types and the UTF-8 encoding function for the cell row encoder.
package cre_pkg;

   localparam int CP_WIDTH = 21;
   localparam logic [7:0] SPACE_LIMIT = 8'd255;
   localparam logic [CP_WIDTH-1:0] CP_SPACE = 21'h20;

   localparam logic [7:0] LEAD_TWO = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR = 8'hF0;
   localparam logic [7:0] CONT_MARK = 8'h80;

   localparam logic [2:0] COUNT_NONE = 3'd0;
   localparam logic [2:0] COUNT_ONE = 3'd1;
   localparam logic [2:0] COUNT_TWO = 3'd2;
   localparam logic [2:0] COUNT_THREE = 3'd3;
   localparam logic [2:0] COUNT_FOUR = 3'd4;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                wide_right_half;
      logic                row_last;
   } cell_type;

   typedef struct packed {
      logic [7:0] spaces_before;
      logic [2:0] byte_count;
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [7:0] byte_fourth;
      logic       row_end;
   } rsp_type;

   typedef struct packed {
      logic [2:0] byte_count;
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [7:0] byte_fourth;
   } utf8_type;

   function automatic utf8_type encode_utf8(input logic [CP_WIDTH-1:0] cp);
      utf8_type enc;
      enc = '0;
      if (cp[20:7] == '0) begin
         enc.byte_count = COUNT_ONE;
         enc.byte_first = {1'b0, cp[6:0]};
      end else if (cp[20:11] == '0) begin
         enc.byte_count = COUNT_TWO;
         enc.byte_first = LEAD_TWO | {3'b000, cp[10:6]};
         enc.byte_second = CONT_MARK | {2'b00, cp[5:0]};
      end else if (cp[20:16] == '0) begin
         enc.byte_count = COUNT_THREE;
         enc.byte_first = LEAD_THREE | {4'b0000, cp[15:12]};
         enc.byte_second = CONT_MARK | {2'b00, cp[11:6]};
         enc.byte_third = CONT_MARK | {2'b00, cp[5:0]};
      end else begin
         enc.byte_count = COUNT_FOUR;
         enc.byte_first = LEAD_FOUR | {5'b00000, cp[20:18]};
         enc.byte_second = CONT_MARK | {2'b00, cp[17:12]};
         enc.byte_third = CONT_MARK | {2'b00, cp[11:6]};
         enc.byte_fourth = CONT_MARK | {2'b00, cp[5:0]};
      end
      return enc;
   endfunction

endpackage

[hw/rtl/cre_in_stage.sv]
// Input register stage holding one cell request.
module cre_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [20:0]                req_code_point,
   input  logic                       req_wide_right_half,
   input  logic                       req_row_last,
   input  logic                       advance,
   output logic                       cell_valid,
   output cre_pkg::cell_type          cell_data
);
   import cre_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   cell_type cell_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cell_ff.code_point <= req_code_point;
         cell_ff.wide_right_half <= req_wide_right_half;
         cell_ff.row_last <= req_row_last;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_data = cell_ff;
endmodule

[hw/rtl/cre_row_core.sv]
// Blank tracking, pending space count and UTF-8 encoding for one cell.
module cre_row_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cell_valid,
   input  cre_pkg::cell_type    cell_data,
   input  logic                 out_free,
   output logic                 advance,
   output logic                 produce,
   output cre_pkg::rsp_type     rsp
);
   import cre_pkg::*;

   logic [7:0]          pending_ff;
   logic [7:0]          pending_in;
   logic [CP_WIDTH-1:0] cp_eff;
   logic                blank;
   utf8_type            enc;

   assign cp_eff = (cell_data.code_point == '0) ? CP_SPACE : cell_data.code_point;
   assign blank = cell_data.wide_right_half || (cp_eff == CP_SPACE);
   assign produce = blank ? cell_data.row_last : 1'b1;
   assign advance = cell_valid && (!produce || out_free);
   assign enc = encode_utf8(cp_eff);

   always_comb begin
      pending_in = pending_ff;
      if (advance) begin
         if (blank && !cell_data.row_last) begin
            if (!cell_data.wide_right_half && (pending_ff != SPACE_LIMIT)) begin
               pending_in = pending_ff + 8'd1;
            end
         end else begin
            pending_in = '0;
         end
      end
   end

   always_comb begin
      rsp = '0;
      if (blank) begin
         rsp.row_end = 1'b1;
      end else begin
         rsp.spaces_before = pending_ff;
         rsp.byte_count = enc.byte_count;
         rsp.byte_first = enc.byte_first;
         rsp.byte_second = enc.byte_second;
         rsp.byte_third = enc.byte_third;
         rsp.byte_fourth = enc.byte_fourth;
         rsp.row_end = cell_data.row_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end
endmodule

[hw/rtl/cell_row_utf8_encoder.sv]
// Top level of the cell row UTF-8 encoder with the result register.
//
//   channel  prefix  direction  contents
//   cells    req_    in         code_point, wide_right_half, row_last
//   output   rsp_    out        spaces_before, byte_count, four bytes, row_end
//
// A request passes the input register, then its result enters the result register.
// One request per cycle unless stalled; input and result registers decouple.
// Blank cells not ending the row give no result; only spaces raise the space count.
// Synchronous reset clears both valid flags and the pending space count.
// A stalled result holds the stage behind it once that stage has a result to give.
module cell_row_utf8_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [20:0] req_code_point,
   input  logic        req_wide_right_half,
   input  logic        req_row_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_spaces_before,
   output logic [2:0]  rsp_byte_count,
   output logic [7:0]  rsp_byte_first,
   output logic [7:0]  rsp_byte_second,
   output logic [7:0]  rsp_byte_third,
   output logic [7:0]  rsp_byte_fourth,
   output logic        rsp_row_end
);
   import cre_pkg::*;

   logic     cell_valid;
   cell_type cell_data;
   logic     advance;
   logic     produce;
   logic     out_free;
   rsp_type  rsp_next;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     load;

   cre_in_stage u_in_stage (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_code_point      (req_code_point),
      .req_wide_right_half (req_wide_right_half),
      .req_row_last        (req_row_last),
      .advance             (advance),
      .cell_valid          (cell_valid),
      .cell_data           (cell_data)
   );

   cre_row_core u_row_core (
      .clock      (clock),
      .reset      (reset),
      .cell_valid (cell_valid),
      .cell_data  (cell_data),
      .out_free   (out_free),
      .advance    (advance),
      .produce    (produce),
      .rsp        (rsp_next)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load = advance && produce;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_spaces_before = rsp_ff.spaces_before;
   assign rsp_byte_count = rsp_ff.byte_count;
   assign rsp_byte_first = rsp_ff.byte_first;
   assign rsp_byte_second = rsp_ff.byte_second;
   assign rsp_byte_third = rsp_ff.byte_third;
   assign rsp_byte_fourth = rsp_ff.byte_fourth;
   assign rsp_row_end = rsp_ff.row_end;
endmodule

[hw/rtl/cre_checker.sv]
// Port-level checker for the cell row UTF-8 encoder, with its bind.
module cre_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_spaces_before,
   input logic [2:0]  rsp_byte_count,
   input logic [7:0]  rsp_byte_first,
   input logic [7:0]  rsp_byte_second,
   input logic [7:0]  rsp_byte_third,
   input logic [7:0]  rsp_byte_fourth,
   input logic        rsp_row_end
);
   import cre_pkg::*;

   // a stalled response stays valid with the same spaces, byte count, first byte and row_end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_spaces_before) && $stable(rsp_byte_count)
         && $stable(rsp_byte_first) && $stable(rsp_row_end))
      else $error("response payload changed while stalled");

   // bare end marker carries nothing but row_end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == COUNT_NONE |-> rsp_row_end
         && rsp_spaces_before == 8'd0 && rsp_byte_first == 8'd0
         && rsp_byte_second == 8'd0 && rsp_byte_third == 8'd0 && rsp_byte_fourth == 8'd0)
      else $error("malformed end marker");

   // byte count legal and fourth byte zero unless four bytes are used
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count == COUNT_NONE || rsp_byte_count == COUNT_ONE
         || rsp_byte_count == COUNT_TWO || rsp_byte_count == COUNT_THREE
         || rsp_byte_count == COUNT_FOUR)
         && (rsp_byte_count == COUNT_FOUR || rsp_byte_fourth == 8'd0))
      else $error("bad byte count or stray fourth byte");

   // a single-byte character is plain ASCII
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == COUNT_ONE |-> !rsp_byte_first[7]
         && rsp_byte_second == 8'd0 && rsp_byte_third == 8'd0)
      else $error("bad single-byte encoding");
endmodule

bind cell_row_utf8_encoder cre_checker u_cre_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_spaces_before (rsp_spaces_before),
   .rsp_byte_count    (rsp_byte_count),
   .rsp_byte_first    (rsp_byte_first),
   .rsp_byte_second   (rsp_byte_second),
   .rsp_byte_third    (rsp_byte_third),
   .rsp_byte_fourth   (rsp_byte_fourth),
   .rsp_row_end       (rsp_row_end)
);
